// ===== hdl/assert_macros.svh =====
// Assertion macros used by the top level of the stack walk block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/ecsw_pkg.sv =====
// Types, constants and state encoding shared by the stack walk block.
package ecsw_pkg;

  localparam int unsigned MAX_VERTICES_DEF = 8;
  localparam int unsigned STACK_DEPTH_DEF  = 37;
  localparam int unsigned RESULT_CAP       = 36;
  localparam int unsigned ROW_COLS         = 8;
  localparam int unsigned VERTEX_W         = 3;
  localparam int unsigned VC_W             = 4;
  localparam int unsigned COUNT_W          = $clog2(RESULT_CAP + 1);
  localparam logic [VC_W-1:0] VC_RESET     = 4'd8;

  typedef logic [VERTEX_W-1:0] vertex_t;

  typedef struct packed {
    logic [2:0] row_index;
    logic [7:0] row_bits;
    logic       last_row;
  } item_t;

  typedef struct packed {
    logic [2:0] from_vertex;
    logic [2:0] to_vertex;
    logic       last_edge;
  } result_t;

  // Answer of the lowest-edge finder.
  typedef struct packed {
    logic    found;
    vertex_t col;
  } find_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_POP,
    ST_FINISH
  } state_t;

endpackage

// ===== hdl/ecsw_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module ecsw_ram #(
  parameter int unsigned WIDTH = 3,
  parameter int unsigned DEPTH = 37
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/ecsw_find.sv =====
// Lowest-numbered unused edge finder over one adjacency row, limited to the active columns.
module ecsw_find import ecsw_pkg::*; (
  input  logic [ROW_COLS-1:0] row,
  input  logic [VC_W-1:0]     ncols,
  output find_t               hit
);

  logic [ROW_COLS-1:0] masked;

  always_comb begin
    for (int j = 0; j < ROW_COLS; j++) begin
      masked[j] = row[j] && (VC_W'(j) < ncols);
    end
  end

  // Scanning from the top down leaves the lowest set column in place.
  always_comb begin
    hit.found = |masked;
    hit.col   = '0;
    for (int j = ROW_COLS - 1; j >= 0; j--) begin
      if (masked[j]) begin
        hit.col = VERTEX_W'(j);
      end
    end
  end

endmodule

// ===== hdl/euler_cycle_stack_walk_top.sv =====
// Top level of the Euler circuit stack walk: matrix rows, walk sequencer and result register.
`include "assert_macros.svh"

// The block holds an undirected adjacency matrix that is loaded one row per input
// transaction, one transaction per cycle while item_stall is low. The transaction whose
// last_row bit is set stores its row and then starts a Hierholzer walk from vertex 0;
// item_stall stays high until the walk has finished and its last result has been moved
// into the output register. Each walk step looks at the vertex on top of the stack
// through a single shared lowest-edge finder: taking an edge stays in the scan state, a
// pop that yields a result passes through the pop state (the stack lives in a RAM with a
// registered read), and the walk closes in the finish state. Pops and closing the walk
// wait while the output register is full and the downstream side holds result_stall high.
// Each result is held back by one step so that last_edge can be set on the final edge of
// the circuit; a walk stops after 36 results and leaves any untaken edges in the matrix.
// The vertex_count register limits the columns the walk looks at; it is written over the
// cfg channel, which is ready whenever no walk is in progress.
module euler_cycle_stack_walk_top import ecsw_pkg::*; #(
  parameter int unsigned MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int unsigned STACK_DEPTH  = STACK_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  output logic            item_stall,
  input  item_t           item,
  output logic            result_valid,
  input  logic            result_stall,
  output result_t         result,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [VC_W-1:0] cfg_data
);

  // Rows beyond the eighth can never be addressed, so storage stops there.
  localparam int unsigned ROWS = (MAX_VERTICES < ROW_COLS) ? MAX_VERTICES : ROW_COLS;
  localparam int unsigned RW   = $clog2(ROWS);
  localparam int unsigned SW   = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW   = $clog2(STACK_DEPTH);
  localparam logic [VC_W-1:0] ROWS_V = VC_W'(ROWS);

  state_t              state;
  state_t              state_next;
  logic [VC_W-1:0]     vertex_count;
  logic [ROW_COLS-1:0] edges [ROWS];
  vertex_t             top;
  logic [SW-1:0]       depth;
  logic [COUNT_W-1:0]  count;
  logic                pend_valid;
  result_t             pend;

  logic [VC_W-1:0]     ncols;
  find_t               hit;
  logic [SW-1:0]       depth_m1;
  logic [SW-1:0]       depth_m2;
  vertex_t             below;
  logic                item_accept;
  logic                out_free;
  logic                depth_full;
  logic                take;
  logic                scan_pop;
  logic                pop_go;
  logic                fin_go;
  logic                out_push;
  result_t             out_word;

  assign item_stall  = (state != ST_IDLE);
  assign cfg_ready   = (state == ST_IDLE);
  assign item_accept = item_valid && !item_stall;

  // Columns in use saturate at the number of stored rows.
  assign ncols    = (vertex_count > ROWS_V) ? ROWS_V : vertex_count;
  assign depth_m1 = depth - SW'(1);
  assign depth_m2 = depth - SW'(2);

  ecsw_find u_find (
    .row   (edges[top[RW-1:0]]),
    .ncols (ncols),
    .hit   (hit)
  );

  // The stack RAM holds every entry below the top; the top itself sits in a register.
  ecsw_ram #(
    .WIDTH (VERTEX_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (take),
    .waddr (depth_m1[AW-1:0]),
    .wdata (top),
    .re    (scan_pop),
    .raddr (depth_m2[AW-1:0]),
    .rdata (below)
  );

  // Control decoded from the sequencer state.
  always_comb begin
    out_free   = !result_valid || !result_stall;
    depth_full = (depth == SW'(STACK_DEPTH));
    take       = (state == ST_SCAN) && hit.found && !depth_full;
    scan_pop   = (state == ST_SCAN) && !take && (depth >= SW'(2));
    pop_go     = (state == ST_POP) && (!pend_valid || out_free);
    fin_go     = (state == ST_FINISH) && (!pend_valid || out_free);
    out_push   = (pop_go || fin_go) && pend_valid;
    out_word   = pend;
    out_word.last_edge = fin_go;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (item_accept && item.last_row) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (take) begin
          state_next = ST_SCAN;
        end else if (scan_pop) begin
          state_next = ST_POP;
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_POP: begin
        if (pop_go) begin
          state_next = (count == COUNT_W'(RESULT_CAP - 1)) ? ST_FINISH : ST_SCAN;
        end
      end
      ST_FINISH: begin
        if (fin_go) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control state, the matrix and the counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      vertex_count <= VC_RESET;
      depth        <= '0;
      count        <= '0;
      pend_valid   <= 1'b0;
      result_valid <= 1'b0;
      for (int r = 0; r < ROWS; r++) begin
        edges[r] <= '0;
      end
    end else begin
      state <= state_next;

      if (cfg_valid && cfg_ready) begin
        vertex_count <= cfg_data;
      end

      if (item_accept) begin
        if ({1'b0, item.row_index} < ROWS_V) begin
          edges[item.row_index[RW-1:0]] <= item.row_bits;
        end
        if (item.last_row) begin
          depth <= SW'(1);
          count <= '0;
        end
      end

      // Taking an edge clears it in both directions, even if the matrix is one-sided.
      if (take) begin
        edges[top[RW-1:0]][hit.col] <= 1'b0;
        if ({1'b0, hit.col} < ROWS_V) begin
          edges[hit.col[RW-1:0]][top] <= 1'b0;
        end
        depth <= depth + SW'(1);
      end

      if (pop_go) begin
        depth      <= depth_m1;
        count      <= count + COUNT_W'(1);
        pend_valid <= 1'b1;
      end

      // Closing a walk empties the stack, also when it stopped at the result limit.
      if (fin_go) begin
        depth      <= '0;
        pend_valid <= 1'b0;
      end

      if (out_push) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (item_accept && item.last_row) begin
      top <= '0;
    end else if (take) begin
      top <= hit.col;
    end else if (pop_go) begin
      top <= below;
    end

    if (pop_go) begin
      pend.from_vertex <= top;
      pend.to_vertex   <= below;
      pend.last_edge   <= 1'b0;
    end

    if (out_push) begin
      result <= out_word;
    end
  end

  `ASSERT_ALWAYS(a_depth_bound, clk, rst, depth <= SW'(STACK_DEPTH), "stack depth overrun")
  `ASSERT_ALWAYS(a_count_bound, clk, rst, count <= COUNT_W'(RESULT_CAP), "result count overrun")
  `ASSERT_IMPLIES(a_idle_clean, clk, rst, state == ST_IDLE, depth == '0 && !pend_valid,
                  "idle with walk left over")
  `ASSERT_NEXT(a_last_flag, clk, rst, fin_go && pend_valid, result_valid && result.last_edge,
               "final edge not flagged")

endmodule
